/* rtl/ycbr_pkg.sv */
// ycbr_pkg: shared types, widths and coefficients for the 4:2:0 block to RGB converter.
// No dependencies; used by every other file under rtl.
`timescale 1ns / 1ps

package ycbr_pkg;

  localparam int PIX_W  = 8;
  localparam int FRAC_W = 12;
  // widest chroma term is about 7258*128 + 2048, needs 20 bits plus sign
  localparam int TERM_W = 22;
  // chroma term after the fractional shift, signed
  localparam int OFF_W  = TERM_W - FRAC_W;
  // luma plus offset before saturation, signed
  localparam int SUM_W  = OFF_W + 1;

  localparam logic signed [TERM_W-1:0] COEF_R_CR = TERM_W'(5743);
  localparam logic signed [TERM_W-1:0] COEF_G_CB = TERM_W'(1410);
  localparam logic signed [TERM_W-1:0] COEF_G_CR = TERM_W'(2925);
  localparam logic signed [TERM_W-1:0] COEF_B_CB = TERM_W'(7258);
  localparam logic signed [TERM_W-1:0] HALF_ULP  = TERM_W'(2048);
  localparam logic signed [PIX_W:0]    CHROMA_MID = (PIX_W+1)'(128);

  // register indexes on the configuration port
  localparam logic [0:0] REG_SWAP_RED_BLUE = 1'b0;

  typedef struct packed {
    logic signed [OFF_W-1:0] red;
    logic signed [OFF_W-1:0] green;
    logic signed [OFF_W-1:0] blue;
  } chroma_off_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  function automatic logic [PIX_W-1:0] sat8(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > SUM_W'(255)) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/ycbr_chroma.sv */
// ycbr_chroma: shared chroma terms of one block, scaled back to whole units.
// Depends on ycbr_pkg.
`timescale 1ns / 1ps

module ycbr_chroma (
  input  logic [ycbr_pkg::PIX_W-1:0] cb,
  input  logic [ycbr_pkg::PIX_W-1:0] cr,
  output ycbr_pkg::chroma_off_t      off
);

  logic signed [ycbr_pkg::PIX_W:0]    cb_s;
  logic signed [ycbr_pkg::PIX_W:0]    cr_s;
  logic signed [ycbr_pkg::TERM_W-1:0] cb_w;
  logic signed [ycbr_pkg::TERM_W-1:0] cr_w;
  logic signed [ycbr_pkg::TERM_W-1:0] rd;
  logic signed [ycbr_pkg::TERM_W-1:0] gd;
  logic signed [ycbr_pkg::TERM_W-1:0] bd;

  assign cb_s = $signed({1'b0, cb}) - ycbr_pkg::CHROMA_MID;
  assign cr_s = $signed({1'b0, cr}) - ycbr_pkg::CHROMA_MID;
  assign cb_w = ycbr_pkg::TERM_W'(cb_s);
  assign cr_w = ycbr_pkg::TERM_W'(cr_s);

  assign rd = cr_w * ycbr_pkg::COEF_R_CR + ycbr_pkg::HALF_ULP;
  assign gd = ycbr_pkg::HALF_ULP - cb_w * ycbr_pkg::COEF_G_CB - cr_w * ycbr_pkg::COEF_G_CR;
  assign bd = cb_w * ycbr_pkg::COEF_B_CB + ycbr_pkg::HALF_ULP;

  // luma*4096 has no fraction, so floor of the sum is luma plus floor of the term
  assign off.red   = rd[ycbr_pkg::TERM_W-1:ycbr_pkg::FRAC_W];
  assign off.green = gd[ycbr_pkg::TERM_W-1:ycbr_pkg::FRAC_W];
  assign off.blue  = bd[ycbr_pkg::TERM_W-1:ycbr_pkg::FRAC_W];

endmodule

/* rtl/ycbr_pixel.sv */
// ycbr_pixel: one pixel's luma plus chroma offsets, saturated, with optional red/blue swap.
// Depends on ycbr_pkg.
`timescale 1ns / 1ps

module ycbr_pixel (
  input  logic [ycbr_pkg::PIX_W-1:0] luma,
  input  ycbr_pkg::chroma_off_t      off,
  input  logic                       swap_rb,
  output ycbr_pkg::rgb_t             rgb
);

  logic signed [ycbr_pkg::SUM_W-1:0] y_s;
  logic [ycbr_pkg::PIX_W-1:0]        r_ch;
  logic [ycbr_pkg::PIX_W-1:0]        g_ch;
  logic [ycbr_pkg::PIX_W-1:0]        b_ch;

  assign y_s  = $signed({{(ycbr_pkg::SUM_W-ycbr_pkg::PIX_W){1'b0}}, luma});
  assign r_ch = ycbr_pkg::sat8(y_s + ycbr_pkg::SUM_W'(off.red));
  assign g_ch = ycbr_pkg::sat8(y_s + ycbr_pkg::SUM_W'(off.green));
  assign b_ch = ycbr_pkg::sat8(y_s + ycbr_pkg::SUM_W'(off.blue));

  assign rgb.red   = swap_rb ? b_ch : r_ch;
  assign rgb.green = g_ch;
  assign rgb.blue  = swap_rb ? r_ch : b_ch;

endmodule

/* rtl/ycbcr420_block_to_rgb_core.sv */
// ycbcr420_block_to_rgb_core: top level, input and result registers, config register.
// Depends on ycbr_pkg, ycbr_chroma and ycbr_pixel.
`timescale 1ns / 1ps

// Converts one 4:2:0 block (four luma bytes plus shared Cb/Cr) into four full-range
// BT.601 RGB pixels per word. A word is accepted every clock while the input register is
// free; the result passes through the input register, then the result register, with the
// conversion done in one pass of constant multiplies, adds and clamps between them.
// Backpressure on the output stalls both registers; the input still takes a word
// while a result waits if the input register is free. swap_red_blue (address 0)
// exchanges red and blue and should only be written while the stream is idle.
module ycbcr420_block_to_rgb_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red; 8 bits each from bit 0 up
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red, green, blue of top_left, then top_right, bottom_left, bottom_right;
  // 8 bits each from bit 0 up
  output logic [95:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW = ycbr_pkg::PIX_W;

  logic        swap_r, swap_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic [47:0] s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r;
  logic        s1_ready, s2_ready;
  logic        cfg_wr;
  logic [0:0]  cfg_idx;

  ycbr_pkg::chroma_off_t off;
  ycbr_pkg::rgb_t        rgb [4];
  logic [95:0]           result;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_idx == ycbr_pkg::REG_SWAP_RED_BLUE) ? {31'd0, swap_r} : 32'd0;
  assign swap_nxt   = (cfg_wr && cfg_idx == ycbr_pkg::REG_SWAP_RED_BLUE) ? cfg_pwdata[0]
                                                                           : swap_r;

  // two-register pipeline, each stage free when empty or draining
  assign s2_ready      = !out_valid_r || out_tready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_tready     = s1_ready;
  assign s1_valid_nxt  = s1_ready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;

  ycbr_chroma u_chroma (
    .cb  (s1_data_r[4*PW +: PW]),
    .cr  (s1_data_r[5*PW +: PW]),
    .off (off)
  );

  for (genvar p = 0; p < 4; p++) begin : g_pix
    ycbr_pixel u_pixel (
      .luma    (s1_data_r[p*PW +: PW]),
      .off     (off),
      .swap_rb (swap_r),
      .rgb     (rgb[p])
    );
    assign result[p*3*PW          +: PW] = rgb[p].red;
    assign result[p*3*PW + PW     +: PW] = rgb[p].green;
    assign result[p*3*PW + 2*PW   +: PW] = rgb[p].blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      swap_r      <= swap_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
    if (s2_ready && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an empty result register never blocks the input
  a_no_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // a word in the input register moves forward when the result side can take it
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("word lost between input and result register");

  // a register write lands on the next edge
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx == ycbr_pkg::REG_SWAP_RED_BLUE) |=> swap_r == $past(cfg_pwdata[0]))
    else $error("swap_red_blue write not taken");

endmodule
